// ===== rtl/fsrs_pkg.sv =====
`default_nettype none
package fsrs_pkg;

  localparam int KEY_W   = 17;
  localparam int SHADE_W = 8;
  localparam int IDX_W   = 6;
  localparam int FIT_W   = 24;

  localparam logic [FIT_W-1:0]   FIT_MAX   = {FIT_W{1'b1}};
  localparam logic [SHADE_W-1:0] SHADE_MAX = {SHADE_W{1'b1}};

  // one stored ranking entry
  typedef struct packed {
    logic             occ;
    logic [FIT_W-1:0] fit;
    logic [IDX_W-1:0] idx;
  } fsrs_entry_t;

  // finished individual leaving the accumulator
  typedef struct packed {
    logic             valid;
    logic             pop;
    logic [FIT_W-1:0] fit;
  } fsrs_ins_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic             ins;
    logic             shift;
    logic [FIT_W-1:0] fit;
    logic [IDX_W-1:0] idx;
  } fsrs_cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/fsrs_front.sv =====
`default_nettype none
module fsrs_front
  import fsrs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               gene_valid,
  input  wire logic [KEY_W-1:0]   key_value,
  input  wire logic [SHADE_W-1:0] target_shade,
  input  wire logic               individual_end,
  input  wire logic               population_end,
  output fsrs_ins_t               ins
);

  localparam int PROD_W = KEY_W + SHADE_W;

  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  rounded;
  logic [PROD_W-17:0] shade_wide;
  logic [SHADE_W-1:0] shade;
  logic [SHADE_W-1:0] diff_next;

  // stage 1
  logic               s1_valid;
  logic               s1_end;
  logic               s1_pop;
  logic [SHADE_W-1:0] s1_diff;

  // stage 2
  logic [FIT_W-1:0]   acc;
  logic [FIT_W:0]     acc_sum;
  logic [FIT_W-1:0]   acc_sat;

  // key * 255 as (key << 8) - key, then round half up, dropping 16 fraction bits
  always_comb begin
    prod       = {key_value, {SHADE_W{1'b0}}} - PROD_W'(key_value);
    rounded    = prod + PROD_W'(32768);
    shade_wide = rounded[PROD_W-1:16];
    shade      = shade_wide[PROD_W-17] ? SHADE_MAX : shade_wide[SHADE_W-1:0];
    diff_next  = (target_shade > shade) ? target_shade - shade : shade - target_shade;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= gene_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_diff <= diff_next;
    s1_end  <= individual_end | population_end;
    s1_pop  <= population_end;
  end

  always_comb begin
    acc_sum = {1'b0, acc} + (FIT_W+1)'(s1_diff);
    acc_sat = acc_sum[FIT_W] ? FIT_MAX : acc_sum[FIT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      ins.valid <= 1'b0;
      ins.pop   <= 1'b0;
    end else begin
      ins.valid <= s1_valid & s1_end;
      ins.pop   <= s1_valid & s1_pop;
      if (s1_valid) begin
        acc <= s1_end ? '0 : acc_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    ins.fit <= acc_sat;
  end

endmodule
`default_nettype wire

// ===== rtl/fsrs_cell.sv =====
`default_nettype none
module fsrs_cell
  import fsrs_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire fsrs_cell_ctl_t  ctl,
  input  wire fsrs_entry_t     prev_entry,
  input  wire logic            prev_stay,
  input  wire fsrs_entry_t     next_entry,
  output fsrs_entry_t          entry,
  output logic                 stay
);

  fsrs_entry_t entry_next;

  // equal fitness stays ahead of the newcomer
  assign stay = entry.occ & (entry.fit <= ctl.fit);

  always_comb begin
    entry_next = entry;
    if (ctl.ins) begin
      if (stay) begin
        entry_next = entry;
      end else if (prev_stay) begin
        entry_next.occ = 1'b1;
        entry_next.fit = ctl.fit;
        entry_next.idx = ctl.idx;
      end else begin
        entry_next = prev_entry;
      end
    end else if (ctl.shift) begin
      entry_next = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.occ <= 1'b0;
    end else begin
      entry.occ <= entry_next.occ;
    end
  end

  always_ff @(posedge clk) begin
    entry.fit <= entry_next.fit;
    entry.idx <= entry_next.idx;
  end

endmodule
`default_nettype wire

// ===== rtl/fitness_sad_rank_sorter.sv =====
`default_nettype none
// Fitness evaluator with a sorted ranking chain. Genes stream in one word per
// cycle while the input is open; each is quantized to a shade, its absolute
// difference from the target is summed into a 24-bit saturating error, and at
// each individual's end the error enters a row of POPULATION_MAX
// compare-and-shift cells, ties kept in arrival order. Individuals past
// capacity are dropped and the overflow flag (tuser on the output) is raised
// for the whole ranking. A word with tlast (population end) closes the
// population: the input then stalls while the gene pipeline (stage 1 and the
// accumulator) settles and the cells shift out one ranked word per accepted
// output cycle; the input reopens once the last ranked word is accepted.
module fitness_sad_rank_sorter
  import fsrs_pkg::*;
#(
  parameter int POPULATION_MAX = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // key_value[16:0], target_shade[24:17], zero
  input  wire logic        s_axis_tuser,  // individual_end
  input  wire logic        s_axis_tlast,  // population_end
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // rank_index[5:0], fitness_error[29:6], zero
  output logic             m_axis_tuser,  // population_overflowed
  output logic             m_axis_tlast   // ranking_last
);

  localparam int CNT_W = $clog2(POPULATION_MAX + 1);

  fsrs_ins_t      ins;
  fsrs_cell_ctl_t ctl;
  fsrs_entry_t    entries [POPULATION_MAX];
  logic           stays   [POPULATION_MAX];

  logic             busy;
  logic             drain;
  logic             ovf;
  logic             ovf_out;
  logic [CNT_W-1:0] count;
  logic             full;
  logic             s_fire;
  logic             m_fire;

  assign s_axis_tready = ~busy;
  assign s_fire        = s_axis_tvalid & s_axis_tready;
  assign m_fire        = m_axis_tvalid & m_axis_tready;
  assign full          = entries[POPULATION_MAX-1].occ;

  fsrs_front u_front (
    .clk            (clk),
    .rst            (rst),
    .gene_valid     (s_fire),
    .key_value      (s_axis_tdata[KEY_W-1:0]),
    .target_shade   (s_axis_tdata[KEY_W+SHADE_W-1:KEY_W]),
    .individual_end (s_axis_tuser),
    .population_end (s_axis_tlast),
    .ins            (ins)
  );

  always_comb begin
    ctl.ins   = ins.valid & ~full;
    ctl.shift = m_fire;
    ctl.fit   = ins.fit;
    ctl.idx   = IDX_W'(count);
  end

  genvar g;
  generate
    for (g = 0; g < POPULATION_MAX; g++) begin : g_cell
      fsrs_entry_t prev_e;
      fsrs_entry_t next_e;
      logic        prev_s;

      if (g == 0) begin : g_head
        assign prev_e = '0;
        assign prev_s = 1'b1;
      end else begin : g_body
        assign prev_e = entries[g-1];
        assign prev_s = stays[g-1];
      end

      if (g == POPULATION_MAX - 1) begin : g_tail
        assign next_e = '0;
      end else begin : g_inner
        assign next_e = entries[g+1];
      end

      fsrs_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .prev_entry (prev_e),
        .prev_stay  (prev_s),
        .next_entry (next_e),
        .entry      (entries[g]),
        .stay       (stays[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      drain   <= 1'b0;
      ovf     <= 1'b0;
      ovf_out <= 1'b0;
      count   <= '0;
    end else begin
      if (s_fire && s_axis_tlast) begin
        busy <= 1'b1;
      end
      if (ins.valid) begin
        if (full) begin
          ovf <= 1'b1;
        end else begin
          count <= count + CNT_W'(1);
        end
        // population closes: latch overflow and start unloading
        if (ins.pop) begin
          drain   <= 1'b1;
          ovf_out <= ovf | full;
          ovf     <= 1'b0;
          count   <= '0;
        end
      end
      if (m_fire && m_axis_tlast) begin
        drain <= 1'b0;
        busy  <= 1'b0;
      end
    end
  end

  always_comb begin
    m_axis_tvalid = drain & entries[0].occ;
    m_axis_tlast  = entries[0].occ & ~entries[1].occ;
    m_axis_tuser  = ovf_out;
    m_axis_tdata  = {(32 - IDX_W - FIT_W)'(0), entries[0].fit, entries[0].idx};
  end

endmodule
`default_nettype wire

// ===== rtl/fsrs_checker.sv =====
`default_nettype none
module fsrs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);

  // input stays closed while rankings are unloading
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input open during ranking output");

  // end of population closes the input on the next cycle
  a_close_on_tlast: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input still open after population end");

  // last ranking word ends the run
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (!m_axis_tvalid && s_axis_tready))
    else $error("output continues after last ranking word");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output word changed");

  a_reset: assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && s_axis_tready))
    else $error("bad state after reset");

endmodule

bind fitness_sad_rank_sorter fsrs_checker u_fsrs_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

// ===== sim/fitness_sad_rank_sorter_test.sv =====
`timescale 1ns / 100ps
module fitness_sad_rank_sorter_test;
  import fsrs_pkg::*;

  localparam int POP_MAX        = 64;
  localparam int IDLE_LIMIT     = 2000;
  localparam int SETTLE_CYCLES  = 100;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int RANDOM_GENES   = 170;
  localparam int PAD_W          = 32 - KEY_W - SHADE_W;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [SHADE_W-1:0] target;
    logic               ind_end;
    logic               pop_end;
  } gene_t;

  typedef struct packed {
    logic [IDX_W-1:0] rank_index;
    logic [FIT_W-1:0] fitness;
    logic             last;
    logic             overflowed;
  } rank_word_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  gene_t      gene_q[$];
  rank_word_t ranking_q[$];
  int         fail_count  = 0;
  int         idle_cycles = 0;

  // sender pacing
  int send_gap  = 0;
  int send_calm = 0;

  // receiver pacing
  int stall_left = 0;
  int recv_calm  = 0;
  int hold_left  = 0;
  bit held_off   = 1'b0;

  // fitness and ranking state
  logic [FIT_W-1:0] run_error = '0;
  int               stored    = 0;
  logic [FIT_W-1:0] chain_fit[POP_MAX];
  logic [IDX_W-1:0] chain_idx[POP_MAX];
  logic             dropped   = 1'b0;

  always #5 clk = ~clk;

  fitness_sad_rank_sorter #(
    .POPULATION_MAX(POP_MAX)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Score one gene; on a population end, queue the whole ranking and clear.
  task automatic score_gene(gene_t g);
    logic [31:0]        scaled;
    logic [SHADE_W-1:0] shade;
    logic [SHADE_W-1:0] diff;
    logic [FIT_W:0]     sum;
    int                 pos;
    rank_word_t         w;
    scaled = (32'(g.key) * 32'd255 + 32'd32768) >> 16;
    shade  = (scaled > 32'(SHADE_MAX)) ? SHADE_MAX : scaled[SHADE_W-1:0];
    diff   = (g.target > shade) ? g.target - shade : shade - g.target;
    sum    = {1'b0, run_error} + (FIT_W + 1)'(diff);
    run_error = sum[FIT_W] ? FIT_MAX : sum[FIT_W-1:0];
    if (g.ind_end || g.pop_end) begin
      if (stored >= POP_MAX) begin
        dropped = 1'b1;
      end else begin
        // equal fitness goes behind what is already stored
        pos = 0;
        while (pos < stored && chain_fit[pos] <= run_error) pos++;
        for (int i = stored; i > pos; i--) begin
          chain_fit[i] = chain_fit[i-1];
          chain_idx[i] = chain_idx[i-1];
        end
        chain_fit[pos] = run_error;
        chain_idx[pos] = IDX_W'(stored);
        stored++;
      end
      run_error = '0;
    end
    if (g.pop_end) begin
      for (int i = 0; i < stored; i++) begin
        w.rank_index = chain_idx[i];
        w.fitness    = chain_fit[i];
        w.last       = (i == stored - 1);
        w.overflowed = dropped;
        ranking_q.push_back(w);
      end
      stored  = 0;
      dropped = 1'b0;
    end
  endtask

  task automatic push_gene(int unsigned key, int unsigned target, bit ie, bit pe);
    gene_t g;
    g.key     = KEY_W'(key);
    g.target  = SHADE_W'(target);
    g.ind_end = ie;
    g.pop_end = pe;
    gene_q.push_back(g);
  endtask

  task automatic push_individual(int genes, bit closes_pop);
    int unsigned key;
    int unsigned target;
    bit          tie_prone;
    tie_prone = ($urandom_range(0, 9) == 0);
    for (int n = 0; n < genes; n++) begin
      if (tie_prone) begin
        key    = $urandom_range(0, 1024);
        target = $urandom_range(0, 3);
      end else begin
        key    = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 65536)
                                              : $urandom_range(0, 131071);
        target = $urandom_range(0, 255);
      end
      if (n == genes - 1)
        push_gene(key, target, closes_pop ? $urandom_range(0, 1) : 1, closes_pop);
      else
        push_gene(key, target, 1'b0, 1'b0);
    end
  endtask

  initial begin
    int randomized;
    int members;
    int genes;
    bit crowded;

    // extremes, clamping, exact half, ties, both end marks together
    push_gene(0, 0, 1, 0);
    push_gene(65536, 255, 1, 0);
    push_gene(131071, 0, 1, 0);
    push_gene(32768, 128, 1, 0);
    push_gene(32767, 128, 1, 0);
    push_gene('h15555, 'hAA, 0, 0);
    push_gene('h0AAAA, 'h55, 1, 0);
    push_gene(0, 255, 0, 0);
    push_gene(65536, 0, 1, 0);
    push_gene(0, 5, 1, 0);
    push_gene(0, 5, 1, 0);
    push_gene(0, 7, 1, 1);
    // population end alone closes the individual
    push_gene(100, 3, 0, 1);
    // exactly full chain, then more arrivals than it holds
    for (int n = 0; n < POP_MAX; n++)
      push_gene($urandom_range(0, 1024), $urandom_range(0, 7), 1, n == POP_MAX - 1);
    for (int n = 0; n < POP_MAX + 6; n++)
      push_gene($urandom_range(0, 1024), $urandom_range(0, 7), 1, n == POP_MAX + 5);
    push_gene(0, 255, 1, 0);
    push_gene(65536, 0, 0, 1);

    randomized = 0;
    while (randomized < RANDOM_GENES) begin
      crowded = ($urandom_range(0, 19) == 0);
      members = crowded ? $urandom_range(60, 70) : $urandom_range(1, 8);
      for (int m = 0; m < members; m++) begin
        if (crowded) genes = 1;
        else genes = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5);
        push_individual(genes, m == members - 1);
        randomized += genes;
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (gene_q.size() != 0) @(posedge clk);
    @(posedge clk);
    while (s_axis_tvalid || ranking_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk) begin : feed
    gene_t g;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      s_axis_tlast  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        score_gene(gene_t'({s_axis_tdata[KEY_W-1:0], s_axis_tdata[KEY_W +: SHADE_W],
                            s_axis_tuser, s_axis_tlast}));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap      <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (gene_q.size() != 0) begin
          g = gene_q.pop_front();
          s_axis_tdata  <= {{PAD_W{1'b0}}, g.target, g.key};
          s_axis_tuser  <= g.ind_end;
          s_axis_tlast  <= g.pop_end;
          s_axis_tvalid <= 1'b1;
          if (send_calm > 0) begin
            send_calm <= send_calm - 1;
            send_gap  <= 0;
          end else begin
            send_gap <= draw_gap();
            if ($urandom_range(0, 199) == 0) send_calm <= $urandom_range(50, 200);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : collect
    rank_word_t       want;
    logic [IDX_W-1:0] got_index;
    logic [FIT_W-1:0] got_fitness;
    int               stall;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_index   = m_axis_tdata[IDX_W-1:0];
        got_fitness = m_axis_tdata[IDX_W +: FIT_W];
        if (ranking_q.size() == 0) begin
          $error("unexpected ranking word: rank_index %0d fitness_error %0d",
                 got_index, got_fitness);
          fail_count++;
        end else begin
          want = ranking_q.pop_front();
          if (got_index !== want.rank_index) begin
            $error("rank_index: expected %0d, got %0d", want.rank_index, got_index);
            fail_count++;
          end
          if (got_fitness !== want.fitness) begin
            $error("fitness_error: expected %0d, got %0d", want.fitness, got_fitness);
            fail_count++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("ranking_last: expected %0d, got %0d", want.last, m_axis_tlast);
            fail_count++;
          end
          if (m_axis_tuser !== want.overflowed) begin
            $error("population_overflowed: expected %0d, got %0d",
                   want.overflowed, m_axis_tuser);
            fail_count++;
          end
        end
      end

      if (recv_calm > 0) recv_calm <= recv_calm - 1;
      else if ($urandom_range(0, 299) == 0) recv_calm <= $urandom_range(100, 400);

      if (hold_left > 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!held_off && m_axis_tvalid && ranking_q.size() >= POP_MAX / 2) begin
        // hold off a long ranking so the block backs up into its input
        held_off      <= 1'b1;
        hold_left     <= HOLDOFF_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left    <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        stall = (recv_calm > 0) ? 0 : draw_gap();
        if (stall > 0) begin
          stall_left    <= stall - 1;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== filelist.f =====
rtl/fsrs_pkg.sv
rtl/fsrs_front.sv
rtl/fsrs_cell.sv
rtl/fitness_sad_rank_sorter.sv
rtl/fsrs_checker.sv
sim/fitness_sad_rank_sorter_test.sv
